FILE: src/arpc_pkg.sv
// ARP cache table: shared types and codes.
// No dependencies; used by the top level, the slot store and the testbench.
package arpc_pkg;

  localparam int unsigned IpW   = 32;
  localparam int unsigned MacW  = 48;
  localparam int unsigned OpW   = 2;
  localparam int unsigned SlotW = 3;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_SAVE   = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOSAVE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } entry_t;

endpackage

FILE: src/arp_cache_table_top.sv
// ARP cache table, top level. Depends on arpc_pkg, arpc_store and arpc_prio.
// One request per cycle while the output is not stalled: a request is captured in
// an input register, all slots are compared against its address in parallel in the
// next cycle, and the store update and result register load happen together once
// the result register is free or being read, so the result is registered and the
// next request already sees the update. Throughput is set by the single
// compare-and-write pass over the slot registers. The store is cleared by
// reset; no clearing pass is needed. entry_index values at or beyond ENTRIES
// read as zero and ignore writes.
module arp_cache_table_top #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [arpc_pkg::OpW-1:0]      operation_i,
  input  logic [arpc_pkg::IpW-1:0]      ip_address_i,
  input  logic [arpc_pkg::MacW-1:0]     mac_address_i,
  input  logic [arpc_pkg::SlotW-1:0]    entry_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [arpc_pkg::MacW-1:0]     found_mac_o,
  output logic [arpc_pkg::IpW-1:0]      found_ip_o,
  output logic [1:0]                    save_status_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // input register
  logic                         req_valid_q;
  arpc_pkg::op_e                op_q;
  logic [arpc_pkg::IpW-1:0]     ip_q;
  logic [arpc_pkg::MacW-1:0]    mac_q;
  logic [arpc_pkg::SlotW-1:0]   idx_q;

  // result register
  logic                         out_valid_q;
  logic                         hit_q, hit_d;
  logic [arpc_pkg::MacW-1:0]    fmac_q, fmac_d;
  logic [arpc_pkg::IpW-1:0]     fip_q, fip_d;
  arpc_pkg::status_e            status_q, status_d;

  logic                         advance;
  logic                         in_take;
  logic [ENTRIES-1:0]           match_vec, free_vec;
  logic                         match_any, free_any;
  logic [IdxW-1:0]              match_idx, free_idx;
  logic [IdxW-1:0]              rd_idx, slot_idx;
  logic                         idx_ok;
  arpc_pkg::entry_t             rd_entry, wr_entry;
  logic                         wr_en;
  logic [IdxW-1:0]              wr_idx;

  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_take) begin
      req_valid_q <= 1'b1;
    end else if (advance) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q  <= arpc_pkg::op_e'(operation_i);
      ip_q  <= ip_address_i;
      mac_q <= mac_address_i;
      idx_q <= entry_index_i;
    end
  end

  arpc_store #(.ENTRIES(ENTRIES)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (ip_q),
    .match_o    (match_vec),
    .free_o     (free_vec),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_entry_i (wr_entry)
  );

  arpc_prio #(.ENTRIES(ENTRIES)) u_match_prio (
    .vec_i (match_vec),
    .any_o (match_any),
    .idx_o (match_idx)
  );

  arpc_prio #(.ENTRIES(ENTRIES)) u_free_prio (
    .vec_i (free_vec),
    .any_o (free_any),
    .idx_o (free_idx)
  );

  assign idx_ok   = (32'(idx_q) < ENTRIES);
  assign slot_idx = IdxW'(idx_q);
  assign rd_idx   = (op_q == arpc_pkg::OP_LOOKUP) ? match_idx : slot_idx;
  assign wr_entry = '{ip: ip_q, mac: mac_q};

  always_comb begin
    hit_d    = 1'b0;
    fmac_d   = '0;
    fip_d    = '0;
    status_d = arpc_pkg::ST_NOSAVE;
    wr_en    = 1'b0;
    wr_idx   = slot_idx;
    case (op_q)
      arpc_pkg::OP_LOOKUP: begin
        if (match_any) begin
          hit_d  = 1'b1;
          fmac_d = rd_entry.mac;
        end
      end
      arpc_pkg::OP_SAVE: begin
        wr_idx = free_idx;
        if (match_any) begin
          status_d = arpc_pkg::ST_PRESENT;
        end else if (free_any) begin
          status_d = arpc_pkg::ST_STORED;
          wr_en    = advance;
        end else begin
          status_d = arpc_pkg::ST_FULL;
        end
      end
      arpc_pkg::OP_READ: begin
        if (idx_ok) begin
          fmac_d = rd_entry.mac;
          fip_d  = rd_entry.ip;
        end
      end
      arpc_pkg::OP_WRITE: begin
        wr_en = advance && idx_ok;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q    <= hit_d;
      fmac_q   <= fmac_d;
      fip_q    <= fip_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign found_mac_o   = fmac_q;
  assign found_ip_o    = fip_q;
  assign save_status_o = status_q;

endmodule

FILE: src/arpc_prio.sv
// ARP cache table: first-set priority encoder over the slot vector.
// Depends on nothing but its parameter.
module arpc_prio #(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned IdxW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0] vec_i,
  output logic               any_o,
  output logic [IdxW-1:0]    idx_o
);

  // lowest set bit wins: scan from the top so the last assignment is the lowest
  always_comb begin
    idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = IdxW'(i);
      end
    end
  end

  assign any_o = |vec_i;

endmodule

FILE: src/arpc_store.sv
// ARP cache table: slot store with parallel address compare.
// Depends on arpc_pkg. Each slot is a register compared against the key.
module arpc_store #(
  parameter int unsigned ENTRIES = 8,
  localparam int unsigned IdxW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [arpc_pkg::IpW-1:0] key_i,
  output logic [ENTRIES-1:0]      match_o,
  output logic [ENTRIES-1:0]      free_o,
  input  logic [IdxW-1:0]         rd_idx_i,
  output arpc_pkg::entry_t        rd_entry_o,
  input  logic                    wr_en_i,
  input  logic [IdxW-1:0]         wr_idx_i,
  input  arpc_pkg::entry_t        wr_entry_i
);

  arpc_pkg::entry_t slot_q [ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      slot_q[wr_idx_i] <= wr_entry_i;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_o[i] = (slot_q[i].ip == key_i);
      free_o[i]  = (slot_q[i].ip == '0);
    end
  end

  assign rd_entry_o = slot_q[rd_idx_i];

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for arp_cache_table_top: a driver and a port monitor
// run against a shadow copy of the slot store. Depends on arpc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int          ENTRIES    = 8;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    arpc_pkg::op_e                  op;
    logic [arpc_pkg::IpW-1:0]   ip;
    logic [arpc_pkg::MacW-1:0]  mac;
    logic [arpc_pkg::SlotW-1:0] idx;
    bit                         drain;   // hold this request until all answers are back
  } request_t;

  typedef struct {
    logic                      hit;
    logic [arpc_pkg::MacW-1:0] mac;
    logic [arpc_pkg::IpW-1:0]  ip;
    arpc_pkg::status_e         status;
  } answer_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic [arpc_pkg::OpW-1:0]   operation_i   = '0;
  logic [arpc_pkg::IpW-1:0]   ip_address_i  = '0;
  logic [arpc_pkg::MacW-1:0]  mac_address_i = '0;
  logic [arpc_pkg::SlotW-1:0] entry_index_i = '0;
  logic                       out_stall_i   = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic                       hit_o;
  logic [arpc_pkg::MacW-1:0]  found_mac_o;
  logic [arpc_pkg::IpW-1:0]   found_ip_o;
  logic [1:0]                 save_status_o;

  request_t                   queued_requests[$];
  answer_t                    pending_answers[$];
  logic [arpc_pkg::IpW-1:0]   shadow_ip  [ENTRIES];
  logic [arpc_pkg::MacW-1:0]  shadow_mac [ENTRIES];
  int                         outstanding = 0;
  int unsigned                mismatches  = 0;
  int unsigned                answers_seen = 0;
  int unsigned                gap_left, send_calm, stall_left, recv_calm;
  int unsigned                idle_cycles = 0;

  arp_cache_table_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .ip_address_i,
    .mac_address_i,
    .entry_index_i,
    .out_valid_o,
    .out_stall_i,
    .hit_o,
    .found_mac_o,
    .found_ip_o,
    .save_status_o
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [arpc_pkg::MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[arpc_pkg::MacW-1:0];
  endfunction

  // First slot holding ip, ENTRIES when none.
  function automatic int find_slot(logic [arpc_pkg::IpW-1:0] ip);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_ip[i] == ip) return i;
    end
    return ENTRIES;
  endfunction

  function automatic answer_t arp_predict(arpc_pkg::op_e op, logic [arpc_pkg::IpW-1:0] ip,
                                          logic [arpc_pkg::MacW-1:0] mac,
                                          logic [arpc_pkg::SlotW-1:0] idx);
    answer_t a;
    int      slot;
    a.hit    = 1'b0;
    a.mac    = '0;
    a.ip     = '0;
    a.status = arpc_pkg::ST_NOSAVE;
    case (op)
      arpc_pkg::OP_LOOKUP: begin
        slot = find_slot(ip);
        if (slot < ENTRIES) begin
          a.hit = 1'b1;
          a.mac = shadow_mac[slot];
        end
      end
      arpc_pkg::OP_SAVE: begin
        if (find_slot(ip) < ENTRIES) begin
          a.status = arpc_pkg::ST_PRESENT;
        end else begin
          slot = find_slot('0);
          if (slot < ENTRIES) begin
            shadow_ip[slot]  = ip;
            shadow_mac[slot] = mac;
            a.status = arpc_pkg::ST_STORED;
          end else begin
            a.status = arpc_pkg::ST_FULL;
          end
        end
      end
      arpc_pkg::OP_READ: begin
        if (int'(idx) < ENTRIES) begin
          a.mac = shadow_mac[idx];
          a.ip  = shadow_ip[idx];
        end
      end
      default: begin
        if (int'(idx) < ENTRIES) begin
          shadow_ip[idx]  = ip;
          shadow_mac[idx] = mac;
        end
      end
    endcase
    return a;
  endfunction

  task automatic add_req(arpc_pkg::op_e op, logic [arpc_pkg::IpW-1:0] ip,
                         logic [arpc_pkg::MacW-1:0] mac,
                         logic [arpc_pkg::SlotW-1:0] idx, bit drain);
    request_t r;
    r.op    = op;
    r.ip    = ip;
    r.mac   = mac;
    r.idx   = idx;
    r.drain = drain;
    queued_requests.push_back(r);
  endtask

  // Request driver
  always @(posedge clk_i) begin : drive_requests
    request_t nxt;
    bit       take;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      take = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (queued_requests.size() != 0 &&
                   !(queued_requests[0].drain && (in_valid_i || outstanding != 0))) begin
        nxt  = queued_requests.pop_front();
        take = 1'b1;
        if (send_calm != 0) begin
          send_calm--;
          gap_left = 0;
        end else begin
          gap_left = pick_delay();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
        end
      end
      in_valid_i <= take;
      if (take) begin
        operation_i   <= nxt.op;
        ip_address_i  <= nxt.ip;
        mac_address_i <= nxt.mac;
        entry_index_i <= nxt.idx;
      end
    end
  end

  // Port monitor: predicts on request accept, checks on answer accept.
  always @(posedge clk_i) begin : watch_ports
    answer_t want;
    bit      in_acc;
    bit      out_acc;
    if (rst_ni) begin
      in_acc  = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      if (in_acc) begin
        pending_answers.push_back(arp_predict(arpc_pkg::op_e'(operation_i), ip_address_i,
                                              mac_address_i, entry_index_i));
      end
      if (out_acc) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          report_mismatch($sformatf("answer %0d with no request pending", answers_seen));
        end else begin
          want = pending_answers.pop_front();
          if (hit_o !== want.hit)
            report_mismatch($sformatf("answer %0d hit %b, want %b",
                                      answers_seen, hit_o, want.hit));
          if (found_mac_o !== want.mac)
            report_mismatch($sformatf("answer %0d found_mac %h, want %h",
                                      answers_seen, found_mac_o, want.mac));
          if (found_ip_o !== want.ip)
            report_mismatch($sformatf("answer %0d found_ip %h, want %h",
                                      answers_seen, found_ip_o, want.ip));
          if (save_status_o !== want.status)
            report_mismatch($sformatf("answer %0d save_status %0d, want %0d",
                                      answers_seen, save_status_o, want.status));
        end
      end
      outstanding <= outstanding + int'(in_acc) - int'(out_acc);
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (recv_calm != 0) begin
          recv_calm--;
        end else begin
          stall_left = pick_delay();
          if ($urandom_range(0, 59) == 0) recv_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [arpc_pkg::IpW-1:0] pool [12];
    logic [arpc_pkg::IpW-1:0] ip;
    arpc_pkg::op_e            op;
    int unsigned              q;
    int unsigned              lo;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_ip[i]  = '0;
      shadow_mac[i] = '0;
    end
    gap_left   = 0;
    send_calm  = 0;
    stall_left = 0;
    recv_calm  = 0;
    pool[0] = '1;
    for (int i = 1; i < 12; i++) pool[i] = $urandom;

    // Empty table: zero address matches free slot 0.
    add_req(arpc_pkg::OP_LOOKUP, '0, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, '0, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_READ, '0, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, '1, '1, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, '1, rand_mac(), 3'd5, 1'b0);
    add_req(arpc_pkg::OP_LOOKUP, '1, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_LOOKUP, 32'h1234_5678, '0, 3'd0, 1'b0);
    // Fill the remaining slots, then overflow.
    add_req(arpc_pkg::OP_SAVE, 32'h0000_0001, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'h8000_0000, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'h7FFF_FFFF, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'h0A00_0001, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'hC0A8_0101, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'h5555_5555, rand_mac(), 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, 32'h0BAD_F00D, rand_mac(), 3'd0, 1'b1);
    // Full table: zero address finds no free slot.
    add_req(arpc_pkg::OP_LOOKUP, '0, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_SAVE, '0, rand_mac(), 3'd0, 1'b0);
    // Free the last slot by writing a zero address.
    add_req(arpc_pkg::OP_WRITE, '0, 48'h5555_5555_5555, 3'd7, 1'b0);
    add_req(arpc_pkg::OP_LOOKUP, '0, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_READ, '0, '0, 3'd7, 1'b0);
    // Duplicate address in a later slot: lookup returns the first.
    add_req(arpc_pkg::OP_WRITE, '1, 48'h0000_0000_0123, 3'd3, 1'b0);
    add_req(arpc_pkg::OP_LOOKUP, '1, '0, 3'd0, 1'b0);
    add_req(arpc_pkg::OP_READ, '0, '0, 3'd3, 1'b0);
    add_req(arpc_pkg::OP_READ, '1, '1, 3'd0, 1'b0);

    for (int n = 0; n < 500; n++) begin
      // occasional sweep that frees every slot
      if ($urandom_range(0, 99) == 0) begin
        for (int s = 0; s < ENTRIES; s++) begin
          add_req(arpc_pkg::OP_WRITE, '0, rand_mac(), s[arpc_pkg::SlotW-1:0], 1'b0);
        end
      end
      q = $urandom_range(0, 99);
      if (q < 35)      op = arpc_pkg::OP_LOOKUP;
      else if (q < 65) op = arpc_pkg::OP_SAVE;
      else if (q < 80) op = arpc_pkg::OP_READ;
      else             op = arpc_pkg::OP_WRITE;
      lo = (op == arpc_pkg::OP_WRITE) ? 30 : 8;
      q  = $urandom_range(0, 99);
      if (q < lo)      ip = '0;
      else if (q < 80) ip = pool[$urandom_range(0, 11)];
      else             ip = $urandom;
      add_req(op, ip, rand_mac(), arpc_pkg::SlotW'($urandom_range(0, 7)),
              $urandom_range(0, 99) == 0);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // negedge: all of the edge's updates have settled
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || pending_answers.size() != 0);
    repeat (10) @(negedge clk_i);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/arpc_pkg.sv
src/arpc_prio.sv
src/arpc_store.sv
src/arp_cache_table_top.sv
tb/testbench.sv
